// ===== src/antialiased_ellipse_coverage_defines.svh =====
// Assertion macros for the anti-aliased ellipse coverage block.
`ifndef ANTIALIASED_ELLIPSE_COVERAGE_DEFINES_SVH
`define ANTIALIASED_ELLIPSE_COVERAGE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AEC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/aec_pkg.sv =====
// Shared constants, types and square root step for the ellipse coverage pipeline.
package aec_pkg;

    // Defaults for the top level parameters
    localparam int COORD_BITS_DEF = 11;
    localparam int SCALE_FRAC_DEF = 16;

    // Fixed field widths
    localparam int RADIUS_BITS = 10;
    localparam int SCALE_BITS  = 36;
    localparam int SPLIT_BITS  = SCALE_BITS / 2;
    localparam int RGB_BITS    = 24;
    localparam int ALPHA_BITS  = 8;
    localparam int CFG_DATA_BITS  = 36;
    localparam int CFG_INDEX_BITS = 3;

    // Square root: radius is taken with 8 fraction bits from a 16 fraction bit value
    localparam int ROOT_FRAC_BITS  = 8;
    localparam int RADIUS_FRAC_IN  = 16;
    localparam int ROOT_BITS       = RADIUS_BITS + ROOT_FRAC_BITS;
    localparam int ROOT_IN_BITS    = 2 * ROOT_BITS;
    localparam int REM_BITS        = ROOT_BITS + 2;
    localparam int STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES     = ROOT_BITS / STEPS_PER_STAGE;

    // Ring distance: 1..256 in 8 fraction bits
    localparam int DIST_BITS = ROOT_FRAC_BITS + 1;
    localparam int DIST_WIDE_BITS = RADIUS_BITS + 1 + ROOT_FRAC_BITS;
    localparam logic [DIST_BITS-1:0] DIST_FULL = DIST_BITS'(1 << ROOT_FRAC_BITS);
    localparam logic [ALPHA_BITS-1:0] ALPHA_MAX = 8'd255;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_MAJOR_RADIUS = 3'd2,
        REG_X_SCALE_SQ   = 3'd3,
        REG_Y_SCALE_SQ   = 3'd4,
        REG_FILL_RGB     = 3'd5,
        REG_FILL_ALPHA   = 3'd6
    } cfg_reg_t;

    // Per-item control that travels with the data between units
    typedef struct packed {
        logic valid;
        logic ring;
    } item_ctl_t;

    // Partial square root: remainder and root bits found so far
    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
    } sqrt_acc_t;

    // One restoring digit step of the integer square root
    function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] pair);
        logic [REM_BITS+1:0] cur;
        logic [REM_BITS+1:0] trial;
        sqrt_acc_t res;
        cur   = {acc.rem, pair};
        trial = {{(REM_BITS - ROOT_BITS){1'b0}}, acc.root, 2'b01};
        if (cur >= trial)
        begin
            res.rem  = REM_BITS'(cur - trial);
            res.root = {acc.root[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            res.rem  = REM_BITS'(cur);
            res.root = {acc.root[ROOT_BITS-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ===== src/antialiased_ellipse_coverage.sv =====
// Top level of the anti-aliased filled ellipse coverage shader.
`include "antialiased_ellipse_coverage_defines.svh"

// Takes one pixel offset per clock while in_ready is high and gives at most
// one pixel for it: solid fill inside the major radius, scaled opacity on the
// one-pixel edge ring, nothing outside, for a zero radius or off the
// coordinate range. The stages are squared radius (squares, split scale
// products, axis sums, final sum and compare), square root at two root bits
// per stage, and coverage and opacity ending in the output register. The
// whole pipeline moves together: it advances whenever the output register is
// empty or its pixel is being taken, so in_ready follows out_ready and one
// pixel per clock flows while the consumer keeps up. Configuration is written
// through cfg_we/cfg_index/cfg_data while no pixel is in flight (the user must
// see to it; the block does not); writes to unknown indexes are dropped.
module antialiased_ellipse_coverage #(
    parameter int COORD_BITS      = aec_pkg::COORD_BITS_DEF,
    parameter int SCALE_FRAC_BITS = aec_pkg::SCALE_FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [aec_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [aec_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // pixel offsets in
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [COORD_BITS-1:0]          offset_x,
    input  logic signed [COORD_BITS-1:0]          offset_y,
    // covered pixels out
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [COORD_BITS-1:0]                 pixel_x,
    output logic [COORD_BITS-1:0]                 pixel_y,
    output logic [aec_pkg::RGB_BITS-1:0]          pixel_rgb,
    output logic [aec_pkg::ALPHA_BITS-1:0]        pixel_alpha,
    output logic                                  is_edge
);

    // ---------------- configuration registers ----------------
    logic [COORD_BITS-1:0]              center_x_reg;
    logic [COORD_BITS-1:0]              center_y_reg;
    logic [aec_pkg::RADIUS_BITS-1:0]    major_radius_reg;
    logic [aec_pkg::SCALE_BITS-1:0]     x_scale_sq_reg;
    logic [aec_pkg::SCALE_BITS-1:0]     y_scale_sq_reg;
    logic [aec_pkg::RGB_BITS-1:0]       fill_rgb_reg;
    logic [aec_pkg::ALPHA_BITS-1:0]     fill_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            major_radius_reg <= '0;
            x_scale_sq_reg   <= aec_pkg::SCALE_BITS'(1) << SCALE_FRAC_BITS;
            y_scale_sq_reg   <= aec_pkg::SCALE_BITS'(1) << SCALE_FRAC_BITS;
            fill_rgb_reg     <= '0;
            fill_alpha_reg   <= aec_pkg::ALPHA_MAX;
        end
        else if (cfg_we)
        begin
            unique case (aec_pkg::cfg_reg_t'(cfg_index))
                aec_pkg::REG_CENTER_X:     center_x_reg     <= cfg_data[COORD_BITS-1:0];
                aec_pkg::REG_CENTER_Y:     center_y_reg     <= cfg_data[COORD_BITS-1:0];
                aec_pkg::REG_MAJOR_RADIUS:
                    major_radius_reg <= cfg_data[aec_pkg::RADIUS_BITS-1:0];
                aec_pkg::REG_X_SCALE_SQ:
                    x_scale_sq_reg   <= cfg_data[aec_pkg::SCALE_BITS-1:0];
                aec_pkg::REG_Y_SCALE_SQ:
                    y_scale_sq_reg   <= cfg_data[aec_pkg::SCALE_BITS-1:0];
                aec_pkg::REG_FILL_RGB:     fill_rgb_reg     <= cfg_data[aec_pkg::RGB_BITS-1:0];
                aec_pkg::REG_FILL_ALPHA:
                    fill_alpha_reg   <= cfg_data[aec_pkg::ALPHA_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    logic adv;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // ---------------- units ----------------
    aec_pkg::item_ctl_t                 rad_ctl;
    logic [COORD_BITS-1:0]              rad_px;
    logic [COORD_BITS-1:0]              rad_py;
    logic [aec_pkg::ROOT_IN_BITS-1:0]   rad_v;

    aec_pkg::item_ctl_t                 sqrt_ctl;
    logic [COORD_BITS-1:0]              sqrt_px;
    logic [COORD_BITS-1:0]              sqrt_py;
    logic [aec_pkg::ROOT_BITS-1:0]      sqrt_root;

    aec_radius #(
        .COORD_BITS      (COORD_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_radius (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (in_valid),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .major_radius (major_radius_reg),
        .x_scale_sq   (x_scale_sq_reg),
        .y_scale_sq   (y_scale_sq_reg),
        .out_ctl      (rad_ctl),
        .out_px       (rad_px),
        .out_py       (rad_py),
        .out_v        (rad_v)
    );

    aec_sqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_ctl   (rad_ctl),
        .in_px    (rad_px),
        .in_py    (rad_py),
        .in_v     (rad_v),
        .out_ctl  (sqrt_ctl),
        .out_px   (sqrt_px),
        .out_py   (sqrt_py),
        .out_root (sqrt_root)
    );

    aec_shade #(
        .COORD_BITS (COORD_BITS)
    ) u_shade (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_ctl       (sqrt_ctl),
        .in_px        (sqrt_px),
        .in_py        (sqrt_py),
        .in_root      (sqrt_root),
        .major_radius (major_radius_reg),
        .fill_alpha   (fill_alpha_reg),
        .out_valid    (out_valid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_alpha  (pixel_alpha),
        .is_edge      (is_edge)
    );

    // color is constant across a run
    assign pixel_rgb = fill_rgb_reg;

    // ---------------- assertions ----------------
    // an interior pixel loaded into the output carries the fill opacity of that cycle
    `AEC_ASSERT_IMPLIES(a_interior_alpha, out_valid && !is_edge && $past(adv), pixel_alpha == $past(fill_alpha_reg), "interior pixel opacity differs from fill opacity")
    // ring coverage only ever lowers the opacity
    `AEC_ASSERT_IMPLIES(a_ring_alpha_bound, out_valid && is_edge && $past(adv), pixel_alpha <= $past(fill_alpha_reg), "edge pixel opacity exceeds fill opacity")

endmodule

// ===== src/aec_radius.sv =====
// Front stages: clipping, scaled squared radius and ring classification.
module aec_radius #(
    parameter int COORD_BITS      = aec_pkg::COORD_BITS_DEF,
    parameter int SCALE_FRAC_BITS = aec_pkg::SCALE_FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  logic signed [COORD_BITS-1:0]          offset_x,
    input  logic signed [COORD_BITS-1:0]          offset_y,
    input  logic [COORD_BITS-1:0]                 center_x,
    input  logic [COORD_BITS-1:0]                 center_y,
    input  logic [aec_pkg::RADIUS_BITS-1:0]       major_radius,
    input  logic [aec_pkg::SCALE_BITS-1:0]        x_scale_sq,
    input  logic [aec_pkg::SCALE_BITS-1:0]        y_scale_sq,
    output aec_pkg::item_ctl_t                    out_ctl,
    output logic [COORD_BITS-1:0]                 out_px,
    output logic [COORD_BITS-1:0]                 out_py,
    output logic [aec_pkg::ROOT_IN_BITS-1:0]      out_v
);

    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int PP_BITS    = SQ_BITS + aec_pkg::SPLIT_BITS;
    localparam int TERM_BITS  = SQ_BITS + aec_pkg::SCALE_BITS;
    localparam int R2_BITS    = TERM_BITS + 1;
    localparam int RSQ_BITS   = 2 * aec_pkg::RADIUS_BITS;
    localparam int R1SQ_BITS  = 2 * (aec_pkg::RADIUS_BITS + 1);
    localparam int BOUND_BITS = R1SQ_BITS + SCALE_FRAC_BITS;
    localparam int CMP_BITS   = (R2_BITS > BOUND_BITS) ? R2_BITS : BOUND_BITS;
    localparam int SPLIT      = aec_pkg::SPLIT_BITS;

    // ---------------- stage 1: coordinates, clip, squares ----------------
    logic [COORD_BITS-1:0]   ox_u;
    logic [COORD_BITS-1:0]   oy_u;
    logic [COORD_BITS-1:0]   ax;
    logic [COORD_BITS-1:0]   ay;
    logic [COORD_BITS+1:0]   px_sum;
    logic [COORD_BITS+1:0]   py_sum;
    logic                    keep1;

    always_comb
    begin
        ox_u   = offset_x;
        oy_u   = offset_y;
        // magnitude; the most negative offset maps to 2^(COORD_BITS-1)
        ax     = ox_u[COORD_BITS-1] ? COORD_BITS'(~ox_u + 1'b1) : ox_u;
        ay     = oy_u[COORD_BITS-1] ? COORD_BITS'(~oy_u + 1'b1) : oy_u;
        px_sum = {2'b00, center_x} + {{2{ox_u[COORD_BITS-1]}}, ox_u};
        py_sum = {2'b00, center_y} + {{2{oy_u[COORD_BITS-1]}}, oy_u};
        keep1  = in_valid && (major_radius != '0)
                 && (px_sum[COORD_BITS+1:COORD_BITS] == 2'b00)
                 && (py_sum[COORD_BITS+1:COORD_BITS] == 2'b00);
    end

    logic                    valid1_reg;
    logic [SQ_BITS-1:0]      axsq1_reg;
    logic [SQ_BITS-1:0]      aysq1_reg;
    logic [COORD_BITS-1:0]   px1_reg;
    logic [COORD_BITS-1:0]   py1_reg;

    // ---------------- stage 2: partial products against the scales ----------------
    logic                    valid2_reg;
    logic [PP_BITS-1:0]      xlo2_reg;
    logic [PP_BITS-1:0]      xhi2_reg;
    logic [PP_BITS-1:0]      ylo2_reg;
    logic [PP_BITS-1:0]      yhi2_reg;
    logic [COORD_BITS-1:0]   px2_reg;
    logic [COORD_BITS-1:0]   py2_reg;

    // ---------------- stage 3: per-axis terms ----------------
    logic                    valid3_reg;
    logic [TERM_BITS-1:0]    xterm3_reg;
    logic [TERM_BITS-1:0]    yterm3_reg;
    logic [COORD_BITS-1:0]   px3_reg;
    logic [COORD_BITS-1:0]   py3_reg;

    // ---------------- stage 4: sum and compare ----------------
    aec_pkg::item_ctl_t                 ctl4_reg;
    logic [COORD_BITS-1:0]              px4_reg;
    logic [COORD_BITS-1:0]              py4_reg;
    logic [aec_pkg::ROOT_IN_BITS-1:0]   v4_reg;

    // Ring bounds follow the radius register every cycle
    logic [aec_pkg::RADIUS_BITS:0]      r1;
    logic [CMP_BITS-1:0]                inner_reg;
    logic [CMP_BITS-1:0]                outer_reg;
    logic [RSQ_BITS-1:0]                rsq;
    logic [R1SQ_BITS-1:0]               r1sq;

    always_comb
    begin
        r1   = {1'b0, major_radius} + 1'b1;
        rsq  = major_radius * major_radius;
        r1sq = r1 * r1;
    end

    always_ff @(posedge clk)
    begin
        inner_reg <= CMP_BITS'({rsq, {SCALE_FRAC_BITS{1'b0}}});
        outer_reg <= CMP_BITS'({r1sq, {SCALE_FRAC_BITS{1'b0}}});
    end

    logic [R2_BITS-1:0]                 r2;
    logic [CMP_BITS-1:0]                r2_cmp;
    logic [aec_pkg::ROOT_IN_BITS-1:0]   v_next;
    aec_pkg::item_ctl_t                 ctl4_next;

    always_comb
    begin
        r2     = {1'b0, xterm3_reg} + {1'b0, yterm3_reg};
        r2_cmp = CMP_BITS'(r2);
        ctl4_next.valid = valid3_reg && (r2_cmp < outer_reg);
        ctl4_next.ring  = r2_cmp > inner_reg;
    end

    // Bring r2 to 16 fraction bits for the root
    generate
        if (SCALE_FRAC_BITS <= aec_pkg::RADIUS_FRAC_IN)
        begin : g_shl
            localparam int SHL = aec_pkg::RADIUS_FRAC_IN - SCALE_FRAC_BITS;
            logic [R2_BITS+SHL-1:0] r2_wide;
            assign r2_wide = (R2_BITS + SHL)'(r2) << SHL;
            assign v_next  = aec_pkg::ROOT_IN_BITS'(r2_wide);
        end
        else
        begin : g_shr
            localparam int SHR = SCALE_FRAC_BITS - aec_pkg::RADIUS_FRAC_IN;
            assign v_next = aec_pkg::ROOT_IN_BITS'(r2 >> SHR);
        end
    endgenerate

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            ctl4_reg   <= '0;
        end
        else if (adv)
        begin
            valid1_reg <= keep1;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            ctl4_reg   <= ctl4_next;
        end
    end

    // Data path
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            axsq1_reg  <= ax * ax;
            aysq1_reg  <= ay * ay;
            px1_reg    <= px_sum[COORD_BITS-1:0];
            py1_reg    <= py_sum[COORD_BITS-1:0];

            xlo2_reg   <= axsq1_reg * x_scale_sq[SPLIT-1:0];
            xhi2_reg   <= axsq1_reg * x_scale_sq[aec_pkg::SCALE_BITS-1:SPLIT];
            ylo2_reg   <= aysq1_reg * y_scale_sq[SPLIT-1:0];
            yhi2_reg   <= aysq1_reg * y_scale_sq[aec_pkg::SCALE_BITS-1:SPLIT];
            px2_reg    <= px1_reg;
            py2_reg    <= py1_reg;

            xterm3_reg <= TERM_BITS'({xhi2_reg, {SPLIT{1'b0}}}) + TERM_BITS'(xlo2_reg);
            yterm3_reg <= TERM_BITS'({yhi2_reg, {SPLIT{1'b0}}}) + TERM_BITS'(ylo2_reg);
            px3_reg    <= px2_reg;
            py3_reg    <= py2_reg;

            px4_reg    <= px3_reg;
            py4_reg    <= py3_reg;
            v4_reg     <= v_next;
        end
    end

    assign out_ctl = ctl4_reg;
    assign out_px  = px4_reg;
    assign out_py  = py4_reg;
    assign out_v   = v4_reg;

endmodule

// ===== src/aec_sqrt.sv =====
// Pipelined integer square root, two result bits per stage.
module aec_sqrt #(
    parameter int COORD_BITS = aec_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  aec_pkg::item_ctl_t                  in_ctl,
    input  logic [COORD_BITS-1:0]               in_px,
    input  logic [COORD_BITS-1:0]               in_py,
    input  logic [aec_pkg::ROOT_IN_BITS-1:0]    in_v,
    output aec_pkg::item_ctl_t                  out_ctl,
    output logic [COORD_BITS-1:0]               out_px,
    output logic [COORD_BITS-1:0]               out_py,
    output logic [aec_pkg::ROOT_BITS-1:0]       out_root
);

    localparam int N  = aec_pkg::SQRT_STAGES;
    localparam int VB = aec_pkg::ROOT_IN_BITS;

    // Stage inputs: index 0 from the ports, index g+1 from stage g
    aec_pkg::item_ctl_t     stage_ctl [N+1];
    logic [COORD_BITS-1:0]  stage_px  [N+1];
    logic [COORD_BITS-1:0]  stage_py  [N+1];
    aec_pkg::sqrt_acc_t     stage_acc [N+1];
    logic [VB-1:0]          stage_v   [N+1];

    assign stage_ctl[0] = in_ctl;
    assign stage_px[0]  = in_px;
    assign stage_py[0]  = in_py;
    assign stage_acc[0] = '0;
    assign stage_v[0]   = in_v;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            aec_pkg::item_ctl_t     ctl_reg;
            logic [COORD_BITS-1:0]  px_reg;
            logic [COORD_BITS-1:0]  py_reg;
            aec_pkg::sqrt_acc_t     acc_reg;
            logic [VB-1:0]          v_reg;
            aec_pkg::sqrt_acc_t     acc_mid;
            aec_pkg::sqrt_acc_t     acc_next;

            // two digit steps, top bit pairs first
            always_comb
            begin
                acc_mid  = aec_pkg::sqrt_step(stage_acc[g], stage_v[g][VB-1:VB-2]);
                acc_next = aec_pkg::sqrt_step(acc_mid, stage_v[g][VB-3:VB-4]);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    ctl_reg <= '0;
                else if (adv)
                    ctl_reg <= stage_ctl[g];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    px_reg  <= stage_px[g];
                    py_reg  <= stage_py[g];
                    acc_reg <= acc_next;
                    v_reg   <= stage_v[g] << (2 * aec_pkg::STEPS_PER_STAGE);
                end
            end

            assign stage_ctl[g+1] = ctl_reg;
            assign stage_px[g+1]  = px_reg;
            assign stage_py[g+1]  = py_reg;
            assign stage_acc[g+1] = acc_reg;
            assign stage_v[g+1]   = v_reg;
        end
    endgenerate

    assign out_ctl  = stage_ctl[N];
    assign out_px   = stage_px[N];
    assign out_py   = stage_py[N];
    assign out_root = stage_acc[N].root;

endmodule

// ===== src/aec_shade.sv =====
// Back stages: ring coverage, opacity scaling and the output register.
module aec_shade #(
    parameter int COORD_BITS = aec_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  aec_pkg::item_ctl_t                  in_ctl,
    input  logic [COORD_BITS-1:0]               in_px,
    input  logic [COORD_BITS-1:0]               in_py,
    input  logic [aec_pkg::ROOT_BITS-1:0]       in_root,
    input  logic [aec_pkg::RADIUS_BITS-1:0]     major_radius,
    input  logic [aec_pkg::ALPHA_BITS-1:0]      fill_alpha,
    output logic                                out_valid,
    output logic [COORD_BITS-1:0]               pixel_x,
    output logic [COORD_BITS-1:0]               pixel_y,
    output logic [aec_pkg::ALPHA_BITS-1:0]      pixel_alpha,
    output logic                                is_edge
);

    localparam int AB   = aec_pkg::ALPHA_BITS;
    localparam int DB   = aec_pkg::DIST_BITS;
    localparam int DWB  = aec_pkg::DIST_WIDE_BITS;
    localparam int PB   = DB + AB;

    // ---------------- stage A: distance to outer edge, coverage ----------------
    logic [aec_pkg::RADIUS_BITS:0]  r1;
    logic [DWB-1:0]                 dist_wide;
    logic [DB-1:0]                  ring_dist;
    logic [PB-1:0]                  cover_prod;

    always_comb
    begin
        r1        = {1'b0, major_radius} + 1'b1;
        dist_wide = {r1, {aec_pkg::ROOT_FRAC_BITS{1'b0}}} - DWB'(in_root);
        // clamp to one full pixel
        if (dist_wide > DWB'(aec_pkg::DIST_FULL))
            ring_dist = aec_pkg::DIST_FULL;
        else
            ring_dist = dist_wide[DB-1:0];
        cover_prod = PB'(ring_dist) * PB'(aec_pkg::ALPHA_MAX);
    end

    aec_pkg::item_ctl_t      ctl_a_reg;
    logic [COORD_BITS-1:0]   px_a_reg;
    logic [COORD_BITS-1:0]   py_a_reg;
    logic [AB-1:0]           cover_a_reg;

    // ---------------- stage B: opacity, output register ----------------
    logic [2*AB-1:0]         alpha_prod;
    logic [AB-1:0]           alpha_next;

    always_comb
    begin
        alpha_prod = fill_alpha * cover_a_reg;
        alpha_next = ctl_a_reg.ring ? alpha_prod[2*AB-1:AB] : fill_alpha;
    end

    logic                    out_valid_reg;
    logic [COORD_BITS-1:0]   pixel_x_reg;
    logic [COORD_BITS-1:0]   pixel_y_reg;
    logic [AB-1:0]           pixel_alpha_reg;
    logic                    is_edge_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctl_a_reg     <= in_ctl;
            out_valid_reg <= ctl_a_reg.valid;
        end
    end

    // coverage is at most 255, so the top product bit stays clear
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_a_reg        <= in_px;
            py_a_reg        <= in_py;
            cover_a_reg     <= cover_prod[2*AB-1:AB];
            pixel_x_reg     <= px_a_reg;
            pixel_y_reg     <= py_a_reg;
            pixel_alpha_reg <= alpha_next;
            is_edge_reg     <= ctl_a_reg.ring;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_alpha = pixel_alpha_reg;
    assign is_edge     = is_edge_reg;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the anti-aliased ellipse coverage shader.
`timescale 1ns / 100ps

module tb_top;

    localparam int CW           = aec_pkg::COORD_BITS_DEF;
    localparam int COORD_MAX    = (1 << CW) - 1;
    localparam int CLK_PERIOD   = 12;
    localparam int PIPE_SETTLE  = 24;      // pipeline is 15 deep
    localparam int DRAIN_SPINS  = 4000;
    localparam int PRINT_LIMIT  = 40;
    localparam int RANDOM_ITEMS = 130;     // per random phase
    localparam int RANDOM_PHASES = 6;

    // index past the register file; the block drops writes to it
    localparam logic [aec_pkg::CFG_INDEX_BITS-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [CW-1:0]                  x;
        logic [CW-1:0]                  y;
        logic [aec_pkg::RGB_BITS-1:0]   rgb;
        logic [aec_pkg::ALPHA_BITS-1:0] alpha;
        logic                           ring;
    } pixel_t;

    typedef struct {
        logic [CW-1:0] dx;
        logic [CW-1:0] dy;
        int            gap;
    } offset_item_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // block ports
    logic                               cfg_we = 1'b0;
    logic [aec_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [aec_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic signed [CW-1:0]               offset_x = '0;
    logic signed [CW-1:0]               offset_y = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [CW-1:0]                      pixel_x;
    logic [CW-1:0]                      pixel_y;
    logic [aec_pkg::RGB_BITS-1:0]       pixel_rgb;
    logic [aec_pkg::ALPHA_BITS-1:0]     pixel_alpha;
    logic                               is_edge;

    // shadow copy of the shape registers
    logic [CW-1:0]                   shape_cx = '0;
    logic [CW-1:0]                   shape_cy = '0;
    logic [aec_pkg::RADIUS_BITS-1:0] shape_radius = '0;
    logic [aec_pkg::SCALE_BITS-1:0]  shape_xs = aec_pkg::SCALE_BITS'(1) << aec_pkg::SCALE_FRAC_DEF;
    logic [aec_pkg::SCALE_BITS-1:0]  shape_ys = aec_pkg::SCALE_BITS'(1) << aec_pkg::SCALE_FRAC_DEF;
    logic [aec_pkg::RGB_BITS-1:0]    shape_rgb = '0;
    logic [aec_pkg::ALPHA_BITS-1:0]  shape_alpha = 8'd255;

    offset_item_t pending_offsets[$];
    pixel_t       expected_pixels[$];
    pixel_t       covered_pixel;
    pixel_t       want_pixel;

    int idle_cycles = 0;
    int hold_left = 0;
    int mode_left = 0;
    int results_seen = 0;
    int error_count = 0;
    int roll;
    bit rx_calm = 1'b0;
    bit in_busy;

    antialiased_ellipse_coverage u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .offset_x   (offset_x),
        .offset_y   (offset_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_rgb  (pixel_rgb),
        .pixel_alpha(pixel_alpha),
        .is_edge    (is_edge)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // floor(sqrt(v)), one root bit at a time from the top
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // coverage of one pixel under the current shape; 0 when nothing is drawn
    function automatic bit shade_pixel(input logic [CW-1:0] dx, input logic [CW-1:0] dy,
                                       output pixel_t px);
        longint sx, sy, col, row;
        longint unsigned ax, ay, rad, r2, inner, outer, norm, root, edge_dist, cov;
        px = '0;
        if (shape_radius == 0)
            return 1'b0;
        sx  = longint'($signed(dx));
        sy  = longint'($signed(dy));
        col = longint'(shape_cx) + sx;
        row = longint'(shape_cy) + sy;
        if (col < 0 || row < 0 || col > COORD_MAX || row > COORD_MAX)
            return 1'b0;
        ax    = (sx < 0) ? -sx : sx;
        ay    = (sy < 0) ? -sy : sy;
        r2    = ax * ax * shape_xs + ay * ay * shape_ys;
        rad   = shape_radius;
        inner = (rad * rad) << aec_pkg::SCALE_FRAC_DEF;
        outer = ((rad + 1) * (rad + 1)) << aec_pkg::SCALE_FRAC_DEF;
        if (r2 >= outer)
            return 1'b0;
        px.x   = col[CW-1:0];
        px.y   = row[CW-1:0];
        px.rgb = shape_rgb;
        if (r2 <= inner)
        begin
            px.alpha = shape_alpha;
            px.ring  = 1'b0;
        end
        else
        begin
            // radius to 8 fraction bits, then distance to the outer edge
            if (aec_pkg::SCALE_FRAC_DEF <= aec_pkg::RADIUS_FRAC_IN)
                norm = r2 << (aec_pkg::RADIUS_FRAC_IN - aec_pkg::SCALE_FRAC_DEF);
            else
                norm = r2 >> (aec_pkg::SCALE_FRAC_DEF - aec_pkg::RADIUS_FRAC_IN);
            root = int_sqrt(norm);
            edge_dist = ((rad + 1) << aec_pkg::ROOT_FRAC_BITS) - root;
            if (edge_dist > 256)
                edge_dist = 256;
            cov      = (edge_dist * 255) >> 8;
            px.alpha = aec_pkg::ALPHA_BITS'((longint'(shape_alpha) * cov) >> 8);
            px.ring  = 1'b1;
        end
        return 1'b1;
    endfunction

    // register write; the shadow copy follows, masked to each width
    task automatic write_reg(input logic [aec_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [aec_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            aec_pkg::REG_CENTER_X:     shape_cx = data[CW-1:0];
            aec_pkg::REG_CENTER_Y:     shape_cy = data[CW-1:0];
            aec_pkg::REG_MAJOR_RADIUS: shape_radius = data[aec_pkg::RADIUS_BITS-1:0];
            aec_pkg::REG_X_SCALE_SQ:   shape_xs = data[aec_pkg::SCALE_BITS-1:0];
            aec_pkg::REG_Y_SCALE_SQ:   shape_ys = data[aec_pkg::SCALE_BITS-1:0];
            aec_pkg::REG_FILL_RGB:     shape_rgb = data[aec_pkg::RGB_BITS-1:0];
            aec_pkg::REG_FILL_ALPHA:   shape_alpha = data[aec_pkg::ALPHA_BITS-1:0];
            default:                   ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random bits above the register's own width
    function automatic logic [aec_pkg::CFG_DATA_BITS-1:0] with_junk(
            input logic [aec_pkg::CFG_DATA_BITS-1:0] v, input int w);
        logic [aec_pkg::CFG_DATA_BITS-1:0] r;
        logic [aec_pkg::CFG_DATA_BITS-1:0] mask;
        r    = aec_pkg::CFG_DATA_BITS'({$urandom, $urandom});
        mask = (aec_pkg::CFG_DATA_BITS'(1) << w) - 1;
        return (r & ~mask) | (v & mask);
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_offset(input int v);
        if (v < -1024)
            return -1024;
        if (v > 1023)
            return 1023;
        return v;
    endfunction

    task automatic queue_offset(input int dx, input int dy, input int gap);
        offset_item_t it;
        it.dx  = CW'(clamp_offset(dx));
        it.dy  = CW'(clamp_offset(dy));
        it.gap = gap;
        pending_offsets.push_back(it);
    endtask

    // half-width of the ellipse along an axis, in pixels, with margin
    function automatic int span_of(input logic [aec_pkg::SCALE_BITS-1:0] scale);
        longint unsigned root;
        longint unsigned v;
        if (scale == 0)
            return 1024;
        root = int_sqrt(scale);
        v    = ((longint'(shape_radius) + 2) << 8) / root + 1;
        return (v > 1024) ? 1024 : int'(v);
    endfunction

    // sender waits for its own queue to go quiet, then lets the pipe empty
    task automatic wait_for_drain();
        int spins;
        while (pending_offsets.size() != 0 || in_valid)
            @(negedge clk);
        spins = 0;
        while (expected_pixels.size() != 0 && spins < DRAIN_SPINS)
        begin
            @(negedge clk);
            spins++;
        end
        repeat (PIPE_SETTLE) @(posedge clk);
        @(negedge clk);
        if (expected_pixels.size() != 0)
        begin
            report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
            expected_pixels.delete();
        end
    endtask

    task automatic random_setup();
        int pick;
        logic [aec_pkg::CFG_DATA_BITS-1:0] v;
        pick = $urandom_range(0, 3);
        v = (pick == 0) ? $urandom_range(0, 40) :
            (pick == 1) ? $urandom_range(2007, 2047) : $urandom_range(0, 2047);
        write_reg(aec_pkg::REG_CENTER_X, with_junk(v, CW));
        pick = $urandom_range(0, 3);
        v = (pick == 0) ? $urandom_range(0, 40) :
            (pick == 1) ? $urandom_range(2007, 2047) : $urandom_range(0, 2047);
        write_reg(aec_pkg::REG_CENTER_Y, with_junk(v, CW));
        pick = $urandom_range(0, 9);
        v = (pick < 5) ? $urandom_range(1, 24) : (pick < 8) ? $urandom_range(25, 200) :
            (pick == 8) ? 1023 : $urandom_range(400, 1022);
        write_reg(aec_pkg::REG_MAJOR_RADIUS, with_junk(v, aec_pkg::RADIUS_BITS));
        for (int a = 0; a < 2; a++)
        begin
            pick = $urandom_range(0, 9);
            v = (pick < 6) ? $urandom_range(1 << 14, 1 << 18) :
                (pick < 8) ? (1 << aec_pkg::SCALE_FRAC_DEF) :
                (pick == 8) ? aec_pkg::CFG_DATA_BITS'({$urandom, $urandom}) : 0;
            write_reg(a == 0 ? aec_pkg::REG_X_SCALE_SQ : aec_pkg::REG_Y_SCALE_SQ, v);
        end
        write_reg(aec_pkg::REG_FILL_RGB, with_junk($urandom, aec_pkg::RGB_BITS));
        pick = $urandom_range(0, 5);
        v = (pick == 0) ? 255 : (pick == 1) ? 0 : $urandom_range(0, 255);
        write_reg(aec_pkg::REG_FILL_ALPHA, with_junk(v, aec_pkg::ALPHA_BITS));
    endtask

    // points near the ellipse edge most often, some inside its box, some anywhere
    task automatic fill_random_phase(input int count);
        int span_x, span_y, free, fit, kind;
        bit calm, swap;
        logic [aec_pkg::SCALE_BITS-1:0] free_scale, fit_scale;
        longint unsigned outer, used, rem;
        span_x = span_of(shape_xs);
        span_y = span_of(shape_ys);
        outer  = ((longint'(shape_radius) + 1) * (longint'(shape_radius) + 1))
                 << aec_pkg::SCALE_FRAC_DEF;
        calm   = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                calm = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 20)
            begin
                queue_offset(int'($urandom_range(0, 2047)) - 1024,
                             int'($urandom_range(0, 2047)) - 1024, calm ? 0 : next_gap());
            end
            else if (kind < 55)
            begin
                queue_offset(int'($urandom_range(0, 2 * span_x)) - span_x,
                             int'($urandom_range(0, 2 * span_y)) - span_y,
                             calm ? 0 : next_gap());
            end
            else
            begin
                swap       = 1'($urandom_range(0, 1));
                free_scale = swap ? shape_ys : shape_xs;
                fit_scale  = swap ? shape_xs : shape_ys;
                free = (swap ? span_y : span_x);
                free = int'($urandom_range(0, 2 * free)) - free;
                used = longint'(free) * longint'(free) * free_scale;
                if (fit_scale == 0 || used >= outer)
                    fit = $urandom_range(0, 8);
                else
                begin
                    rem = outer - used;
                    fit = int'(int_sqrt(rem / fit_scale)) + int'($urandom_range(0, 2)) - 1;
                end
                if ($urandom_range(0, 1))
                    fit = -fit;
                if (swap)
                    queue_offset(fit, free, calm ? 0 : next_gap());
                else
                    queue_offset(free, fit, calm ? 0 : next_gap());
            end
        end
    endtask

    // sender: presents queued offsets, predicts each transfer as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            offset_x    <= '0;
            offset_y    <= '0;
            idle_cycles = 0;
        end
        else
        begin
            in_busy = in_valid;
            if (in_valid && in_ready)
            begin
                if (shade_pixel(offset_x, offset_y, covered_pixel))
                    expected_pixels.push_back(covered_pixel);
                in_busy = 1'b0;
            end
            if (!in_busy)
            begin
                if (pending_offsets.size() != 0 && idle_cycles >= pending_offsets[0].gap)
                begin
                    in_valid    <= 1'b1;
                    offset_x    <= pending_offsets[0].dx;
                    offset_y    <= pending_offsets[0].dy;
                    void'(pending_offsets.pop_front());
                    idle_cycles = 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (pending_offsets.size() != 0)
                        idle_cycles++;
                end
            end
        end
    end

    // receiver: checks each pixel transfer, stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
            mode_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch($sformatf("unexpected pixel (%0d,%0d)", pixel_x, pixel_y));
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    if (pixel_x !== want_pixel.x)
                        report_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x, want_pixel.x));
                    if (pixel_y !== want_pixel.y)
                        report_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y, want_pixel.y));
                    if (pixel_rgb !== want_pixel.rgb)
                        report_mismatch($sformatf("pixel_rgb %06h, want %06h",
                                                  pixel_rgb, want_pixel.rgb));
                    if (pixel_alpha !== want_pixel.alpha)
                        report_mismatch($sformatf("pixel_alpha %0d, want %0d at (%0d,%0d)",
                                                  pixel_alpha, want_pixel.alpha,
                                                  want_pixel.x, want_pixel.y));
                    if (is_edge !== want_pixel.ring)
                        report_mismatch($sformatf("is_edge %0b, want %0b at (%0d,%0d)",
                                                  is_edge, want_pixel.ring,
                                                  want_pixel.x, want_pixel.y));
                end
                results_seen++;
                // long hold-off so the pipeline backs up into the input
                if (results_seen % 250 == 60)
                    hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_calm   = ($urandom_range(0, 2) == 0);
                    mode_left = $urandom_range(20, 200);
                end
                else
                    mode_left--;
                roll = $urandom_range(0, 99);
                if (rx_calm || roll < 70)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    hold_left = (roll < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus phases
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero radius draws nothing
        queue_offset(0, 0, 0);
        queue_offset(5, 5, 0);
        queue_offset(1023, 1023, 0);
        wait_for_drain();

        // circle of radius 100 mid-surface: center, both boundaries, ring, far points
        write_reg(aec_pkg::REG_CENTER_X, 1024);
        write_reg(aec_pkg::REG_CENTER_Y, 1024);
        write_reg(aec_pkg::REG_MAJOR_RADIUS, 100);
        write_reg(aec_pkg::REG_X_SCALE_SQ, 1 << aec_pkg::SCALE_FRAC_DEF);
        write_reg(aec_pkg::REG_Y_SCALE_SQ, 1 << aec_pkg::SCALE_FRAC_DEF);
        write_reg(aec_pkg::REG_FILL_RGB, 24'hFFFFFF);
        write_reg(aec_pkg::REG_FILL_ALPHA, 255);
        @(negedge clk);
        queue_offset(0, 0, 0);
        queue_offset(100, 0, 0);
        queue_offset(101, 0, 1);
        queue_offset(0, -100, 0);
        queue_offset(-71, -71, 0);
        queue_offset(70, 71, 2);
        queue_offset(-100, -14, 0);
        queue_offset(100, 1, 0);
        queue_offset(1023, 1023, 0);
        queue_offset(-1024, -1024, 0);
        queue_offset(-1024, 0, 0);
        wait_for_drain();

        // largest radius at the origin corner: clipping on the low side
        write_reg(aec_pkg::REG_CENTER_X, 0);
        write_reg(aec_pkg::REG_CENTER_Y, 0);
        write_reg(aec_pkg::REG_MAJOR_RADIUS, 1023);
        write_reg(aec_pkg::REG_FILL_RGB, 24'h123456);
        write_reg(aec_pkg::REG_FILL_ALPHA, 128);
        @(negedge clk);
        queue_offset(1023, 0, 0);
        queue_offset(-1, 0, 0);
        queue_offset(0, -1024, 0);
        queue_offset(723, 723, 0);
        queue_offset(724, 724, 0);
        queue_offset(0, 0, 0);
        queue_offset(1023, 1023, 0);
        wait_for_drain();

        // top corner, radius 1, zero and full-scale factors, dropped write
        write_reg(aec_pkg::REG_CENTER_X, 2047);
        write_reg(aec_pkg::REG_CENTER_Y, 2047);
        write_reg(aec_pkg::REG_MAJOR_RADIUS, 1);
        write_reg(aec_pkg::REG_X_SCALE_SQ, 0);
        write_reg(aec_pkg::REG_Y_SCALE_SQ, {aec_pkg::SCALE_BITS{1'b1}});
        write_reg(aec_pkg::REG_FILL_RGB, 0);
        write_reg(aec_pkg::REG_FILL_ALPHA, 0);
        write_reg(REG_NONE, {aec_pkg::CFG_DATA_BITS{1'b1}});
        @(negedge clk);
        queue_offset(0, 0, 0);
        queue_offset(-1024, 0, 0);
        queue_offset(1, 0, 0);
        queue_offset(0, 1, 0);
        queue_offset(-512, 0, 0);
        wait_for_drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_setup();
            @(negedge clk);
            fill_random_phase(RANDOM_ITEMS);
            wait_for_drain();
        end

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== antialiased_ellipse_coverage.f =====
+incdir+src
src/aec_pkg.sv
src/aec_radius.sv
src/aec_sqrt.sv
src/aec_shade.sv
src/antialiased_ellipse_coverage.sv
verif/tb_top.sv
